>>> design/assert_macros.svh
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in the same cycle");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed one cycle later");

`endif

>>> design/aprt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aprt_pkg
// shared types and constants of the affine point and region transform
// ---------------------------------------------------------------------------
package aprt_pkg;

    localparam int APRT_COORD_W   = 32;
    localparam int APRT_FRAC_BITS = 16;
    localparam int APRT_ADDR_W    = 5;
    localparam int APRT_IDX_W     = APRT_ADDR_W - 2;

    // register indexes, byte address is 4 times the index
    localparam logic [APRT_IDX_W-1:0] REG_COEF_A  = 3'd0;
    localparam logic [APRT_IDX_W-1:0] REG_COEF_B  = 3'd1;
    localparam logic [APRT_IDX_W-1:0] REG_COEF_C  = 3'd2;
    localparam logic [APRT_IDX_W-1:0] REG_COEF_D  = 3'd3;
    localparam logic [APRT_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [APRT_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

    typedef enum logic [1:0] {
        OP_POINT   = 2'd0,
        OP_INT_BOX = 2'd1,
        OP_SUB_BOX = 2'd2
    } op_t;

    // how a lane turns the exact sum into a coordinate
    typedef enum logic [1:0] {
        KIND_ROUND = 2'd0,
        KIND_FLOOR = 2'd1,
        KIND_CEIL  = 2'd2
    } kind_t;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic m;
        logic a;
        logic r;
        logic s;
    } stage_en_t;

endpackage

>>> design/aprt_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aprt_lane
// one output coordinate: multiply, sum, round or floor/ceil, saturate
// ---------------------------------------------------------------------------
module aprt_lane import aprt_pkg::*; #(
    parameter int FRAC_BITS = APRT_FRAC_BITS
) (
    input  logic                           aclk,
    input  stage_en_t                      en,
    input  kind_t                          in_kind,
    input  logic                           in_active,
    input  logic signed [APRT_COORD_W-1:0] coef_g1,
    input  logic signed [APRT_COORD_W-1:0] coef_g2,
    input  logic signed [APRT_COORD_W-1:0] coord_u,
    input  logic signed [APRT_COORD_W-1:0] coord_v,
    input  logic signed [APRT_COORD_W-1:0] shift_t,
    output logic signed [APRT_COORD_W-1:0] out_value,
    output logic                           out_ovf
);

    localparam int CW = APRT_COORD_W;
    localparam int PW = 2 * CW;
    localparam int RW = PW + 2;
    localparam int TW = CW + 1;
    localparam int VW = RW + 1 + FRAC_BITS;

    localparam logic signed [RW-1:0] HALF      = (RW'(1) << FRAC_BITS) >> 1;
    localparam logic signed [RW-1:0] CEIL_PROD = (RW'(1) << (2 * FRAC_BITS)) - RW'(1);
    localparam logic signed [TW-1:0] CEIL_T    = (TW'(1) << FRAC_BITS) - TW'(1);
    localparam logic signed [VW-1:0] SAT_MAX   =
        VW'($signed({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [VW-1:0] SAT_MIN   =
        VW'($signed({1'b1, {(CW-1){1'b0}}}));

    // stage m: products
    logic signed [PW-1:0] prod1_reg, prod2_reg;
    kind_t                kind_m_reg;
    logic                 act_m_reg;

    // stage a: product sum, offset, integer translation
    logic signed [RW-1:0] sum_a_reg, sum_a_next;
    logic signed [RW-1:0] off_a_reg, off_a_next;
    logic signed [TW-1:0] tq_a_reg, tq_a_next;
    logic signed [TW-1:0] t_ext;
    kind_t                kind_a_reg;
    logic                 act_a_reg;

    // stage r: rounded sum, or floored or ceiled linear part
    logic signed [RW-1:0] pre_r;
    logic signed [RW-1:0] shr_r_reg, shr_r_next;
    logic signed [TW-1:0] tq_r_reg;
    kind_t                kind_r_reg;
    logic                 act_r_reg;

    // stage s: combine and saturate
    logic signed [RW-1:0] int_sum;
    logic signed [VW-1:0] wide_s;
    logic signed [CW-1:0] value_next;
    logic                 ovf_next;
    logic signed [CW-1:0] value_reg;
    logic                 ovf_reg;

    always_ff @(posedge aclk) begin
        if (en.m) begin
            prod1_reg  <= PW'(coef_g1) * PW'(coord_u);
            prod2_reg  <= PW'(coef_g2) * PW'(coord_v);
            kind_m_reg <= in_kind;
            act_m_reg  <= in_active;
        end
    end

    assign sum_a_next = RW'(prod1_reg) + RW'(prod2_reg);
    assign t_ext      = TW'(shift_t);

    always_comb begin
        unique case (kind_m_reg)
            KIND_FLOOR: begin
                off_a_next = '0;
                tq_a_next  = t_ext >>> FRAC_BITS;
            end
            KIND_CEIL: begin
                off_a_next = CEIL_PROD;
                tq_a_next  = (t_ext + CEIL_T) >>> FRAC_BITS;
            end
            default: begin
                off_a_next = (RW'(shift_t) <<< FRAC_BITS) + HALF;
                tq_a_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.a) begin
            sum_a_reg  <= sum_a_next;
            off_a_reg  <= off_a_next;
            tq_a_reg   <= tq_a_next;
            kind_a_reg <= kind_m_reg;
            act_a_reg  <= act_m_reg;
        end
    end

    assign pre_r      = sum_a_reg + off_a_reg;
    assign shr_r_next = (kind_a_reg == KIND_ROUND) ? (pre_r >>> FRAC_BITS)
                                                   : (pre_r >>> (2 * FRAC_BITS));

    always_ff @(posedge aclk) begin
        if (en.r) begin
            shr_r_reg  <= shr_r_next;
            tq_r_reg   <= tq_a_reg;
            kind_r_reg <= kind_a_reg;
            act_r_reg  <= act_a_reg;
        end
    end

    assign int_sum = shr_r_reg + RW'(tq_r_reg);
    assign wide_s  = (kind_r_reg == KIND_ROUND) ? VW'(shr_r_reg)
                                                : (VW'(int_sum) <<< FRAC_BITS);

    always_comb begin
        priority if (!act_r_reg) begin
            value_next = '0;
            ovf_next   = 1'b0;
        end else if (wide_s > SAT_MAX) begin
            value_next = SAT_MAX[CW-1:0];
            ovf_next   = 1'b1;
        end else if (wide_s < SAT_MIN) begin
            value_next = SAT_MIN[CW-1:0];
            ovf_next   = 1'b1;
        end else begin
            value_next = wide_s[CW-1:0];
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s) begin
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_value = value_reg;
    assign out_ovf   = ovf_reg;

endmodule

>>> design/affine_point_region_transform_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// affine_point_region_transform_core
// 2d affine transform of q16.16 points and boxes, saturating, and while m_ready is high one beat a cycle
// ---------------------------------------------------------------------------
// usage
//   matrix a, b, c, d and translation shift_x, shift_y are written over the
//   apb port (byte offsets 0x00..0x14) while no beat is in flight
//   input beats (s_valid/s_ready) carry an operation and two corners; every
//   input beat gives exactly one result beat (m_valid/m_ready)
//   point mode maps the first corner, the second result corner reads zero;
//   sub-pixel boxes map both corners rounded to nearest; integer boxes floor
//   the first corner and ceil the second
//   path: a taken input beat loads the multiply stage at the accept edge, then
//   passes the product sum, round/shift and saturate stages; the saturate
//   stage register drives the m_ side
//   throughput: one beat per cycle while m_ready is high, set by the four-stage lane pipeline
//   stall: a low m_ready holds the output register; each stage still fills
//   while it is empty, so s_ready drops only once all four stages hold a beat
//   reset: pipeline empties, matrix returns to identity, translation to zero
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_point_region_transform_core import aprt_pkg::*; #(
    parameter int FRAC_BITS = APRT_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APRT_ADDR_W-1:0]         paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic signed [APRT_COORD_W-1:0] s_first_x,
    input  logic signed [APRT_COORD_W-1:0] s_first_y,
    input  logic signed [APRT_COORD_W-1:0] s_second_x,
    input  logic signed [APRT_COORD_W-1:0] s_second_y,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [APRT_COORD_W-1:0] m_out_first_x,
    output logic signed [APRT_COORD_W-1:0] m_out_first_y,
    output logic signed [APRT_COORD_W-1:0] m_out_second_x,
    output logic signed [APRT_COORD_W-1:0] m_out_second_y,
    output logic                           m_overflow
);

    localparam int CW = APRT_COORD_W;

    // identity gain in the chosen fixed-point format
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0]   coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [CW-1:0]   shift_x_reg, shift_y_reg;
    logic                   cfg_wr;
    logic [APRT_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APRT_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg  <= ONE;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= ONE;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end else if (cfg_wr) begin
            // writes past the last register are dropped
            case (cfg_idx)
                REG_COEF_A:  coef_a_reg  <= pwdata;
                REG_COEF_B:  coef_b_reg  <= pwdata;
                REG_COEF_C:  coef_c_reg  <= pwdata;
                REG_COEF_D:  coef_d_reg  <= pwdata;
                REG_SHIFT_X: shift_x_reg <= pwdata;
                REG_SHIFT_Y: shift_y_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_COEF_A:  prdata = coef_a_reg;
            REG_COEF_B:  prdata = coef_b_reg;
            REG_COEF_C:  prdata = coef_c_reg;
            REG_COEF_D:  prdata = coef_d_reg;
            REG_SHIFT_X: prdata = shift_x_reg;
            REG_SHIFT_Y: prdata = shift_y_reg;
            default:     prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // valid bits per stage; a stage loads when it is empty or moves on
    logic      valid_m_reg, valid_a_reg, valid_r_reg, valid_s_reg;
    logic      rdy_m, rdy_a, rdy_r, rdy_s;
    stage_en_t stage_en;

    assign rdy_s = !valid_s_reg || m_ready;
    assign rdy_r = !valid_r_reg || rdy_s;
    assign rdy_a = !valid_a_reg || rdy_r;
    assign rdy_m = !valid_m_reg || rdy_a;

    assign stage_en.m = rdy_m;
    assign stage_en.a = rdy_a;
    assign stage_en.r = rdy_r;
    assign stage_en.s = rdy_s;

    assign s_ready = rdy_m;
    assign m_valid = valid_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_m_reg <= 1'b0;
            valid_a_reg <= 1'b0;
            valid_r_reg <= 1'b0;
            valid_s_reg <= 1'b0;
        end else begin
            if (rdy_m) valid_m_reg <= s_valid;
            if (rdy_a) valid_a_reg <= valid_m_reg;
            if (rdy_r) valid_r_reg <= valid_a_reg;
            if (rdy_s) valid_s_reg <= valid_r_reg;
        end
    end

    // ---------------- operation decode ----------------
    kind_t kind_first, kind_second;
    logic  second_used;

    always_comb begin
        unique case (s_operation)
            OP_INT_BOX: begin
                kind_first  = KIND_FLOOR;
                kind_second = KIND_CEIL;
                second_used = 1'b1;
            end
            OP_SUB_BOX: begin
                kind_first  = KIND_ROUND;
                kind_second = KIND_ROUND;
                second_used = 1'b1;
            end
            // point mode, and the unused code behaves the same
            default: begin
                kind_first  = KIND_ROUND;
                kind_second = KIND_ROUND;
                second_used = 1'b0;
            end
        endcase
    end

    // ---------------- four coordinate lanes ----------------
    // x' = a*x + c*y + shift_x, y' = b*x + d*y + shift_y
    logic ovf_fx, ovf_fy, ovf_sx, ovf_sy;

    aprt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_fx (
        .aclk      (aclk),
        .en        (stage_en),
        .in_kind   (kind_first),
        .in_active (1'b1),
        .coef_g1   (coef_a_reg),
        .coef_g2   (coef_c_reg),
        .coord_u   (s_first_x),
        .coord_v   (s_first_y),
        .shift_t   (shift_x_reg),
        .out_value (m_out_first_x),
        .out_ovf   (ovf_fx)
    );

    aprt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_fy (
        .aclk      (aclk),
        .en        (stage_en),
        .in_kind   (kind_first),
        .in_active (1'b1),
        .coef_g1   (coef_b_reg),
        .coef_g2   (coef_d_reg),
        .coord_u   (s_first_x),
        .coord_v   (s_first_y),
        .shift_t   (shift_y_reg),
        .out_value (m_out_first_y),
        .out_ovf   (ovf_fy)
    );

    // second corner lanes read zero and never flag in point mode
    aprt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_sx (
        .aclk      (aclk),
        .en        (stage_en),
        .in_kind   (kind_second),
        .in_active (second_used),
        .coef_g1   (coef_a_reg),
        .coef_g2   (coef_c_reg),
        .coord_u   (s_second_x),
        .coord_v   (s_second_y),
        .shift_t   (shift_x_reg),
        .out_value (m_out_second_x),
        .out_ovf   (ovf_sx)
    );

    aprt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_sy (
        .aclk      (aclk),
        .en        (stage_en),
        .in_kind   (kind_second),
        .in_active (second_used),
        .coef_g1   (coef_b_reg),
        .coef_g2   (coef_d_reg),
        .coord_u   (s_second_x),
        .coord_v   (s_second_y),
        .shift_t   (shift_y_reg),
        .out_value (m_out_second_y),
        .out_ovf   (ovf_sy)
    );

    assign m_overflow = ovf_fx || ovf_fy || ovf_sx || ovf_sy;

    // ---------------- checks ----------------
    // an empty output register means every stage can take a beat
    `ASSERT_SAME(a_ready_when_drained, aclk, aresetn, !valid_s_reg, s_ready)
    // a register write to coefficient a lands in that register
    `ASSERT_NEXT(a_coef_a_write, aclk, aresetn, cfg_wr && (cfg_idx == REG_COEF_A), coef_a_reg == $past(pwdata))
    // nothing comes out right after reset
    `ASSERT_SAME(a_empty_after_reset, aclk, aresetn, !$past(aresetn), !m_valid)

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// checks the affine point and region transform core against its own
// q16.16 prediction: matrix settings go in over the apb port while the
// pipeline is empty, input beats carry random points and boxes, and every
// result beat is compared field by field with the oldest prediction
// ---------------------------------------------------------------------------
module tb_top;
    import aprt_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PCT        = 14;
    localparam int STALL_LIMIT     = 2000;   // cycles with no beat and no register access
    localparam int DRAIN_CYCLES    = 8;      // four pipeline stages plus margin
    localparam int ITEMS_PER_PHASE = 250;
    localparam int MAX_REPORTS     = 10;

    localparam int CW = APRT_COORD_W;
    localparam int FB = APRT_FRAC_BITS;
    // wide enough for a sum of two full products plus a shifted translation
    localparam int WW = 2 * CW + 32;

    // operation code 3 has no name in the package; the core treats it as a point
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [WW-1:0] wide_t;

    localparam wide_t  ONE_W     = 1;
    localparam wide_t  COORD_MAX = (ONE_W <<< (CW - 1)) - ONE_W;
    localparam wide_t  COORD_MIN = -(ONE_W <<< (CW - 1));
    localparam coord_t C_MAX     = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN     = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t Q_ONE     = coord_t'(1 << FB);
    localparam coord_t Q_HALF    = coord_t'(1 << (FB - 1));

    // one result beat
    typedef struct {
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
        logic   overflow;
    } corner_result_t;

    // -----------------------------------------------------------------------
    // scoreboard: keeps a copy of the matrix, predicts each beat's corners
    // and checks result beats in order
    // -----------------------------------------------------------------------
    class transform_scoreboard;
        coord_t         coef[6];
        corner_result_t expected_corners[$];
        int             mismatches;
        bit             sat_seen;

        function new();
            coef[REG_COEF_A]  = Q_ONE;
            coef[REG_COEF_B]  = '0;
            coef[REG_COEF_C]  = '0;
            coef[REG_COEF_D]  = Q_ONE;
            coef[REG_SHIFT_X] = '0;
            coef[REG_SHIFT_Y] = '0;
            mismatches        = 0;
        endfunction

        function void set_reg(logic [APRT_IDX_W-1:0] idx, logic [31:0] value);
            if (idx <= REG_SHIFT_Y)
                coef[idx] = value;
        endfunction

        // one output coordinate: g1*u + g2*v exact, then translation t
        function coord_t map_coord(coord_t g1, coord_t g2, coord_t u, coord_t v,
                                   coord_t t, kind_t kind);
            wide_t g1w, g2w, uw, vw, lin, tw, sum;
            g1w = g1;
            g2w = g2;
            uw  = u;
            vw  = v;
            tw  = t;
            lin = g1w * uw + g2w * vw;            // scale 2^(2*FB)
            if (kind == KIND_ROUND) begin
                // nearest, ties toward plus infinity
                sum = (lin + (tw <<< FB) + (ONE_W <<< (FB - 1))) >>> FB;
            end else begin
                if (kind == KIND_CEIL) begin
                    lin = lin + (ONE_W <<< (2 * FB)) - ONE_W;
                    tw  = tw + (ONE_W <<< FB) - ONE_W;
                end
                // whole linear part plus whole translation, kept in q format
                sum = ((lin >>> (2 * FB)) <<< FB) + ((tw >>> FB) <<< FB);
            end
            if (sum > COORD_MAX) begin
                sat_seen = 1'b1;
                return C_MAX;
            end
            if (sum < COORD_MIN) begin
                sat_seen = 1'b1;
                return C_MIN;
            end
            return sum[CW-1:0];
        endfunction

        function void note_input(logic [1:0] op, coord_t fx, coord_t fy,
                                 coord_t sx, coord_t sy);
            corner_result_t r;
            kind_t          k1, k2;
            k1       = (op == OP_INT_BOX) ? KIND_FLOOR : KIND_ROUND;
            k2       = (op == OP_INT_BOX) ? KIND_CEIL : KIND_ROUND;
            sat_seen = 1'b0;
            r.first_x = map_coord(coef[REG_COEF_A], coef[REG_COEF_C], fx, fy,
                                  coef[REG_SHIFT_X], k1);
            r.first_y = map_coord(coef[REG_COEF_B], coef[REG_COEF_D], fx, fy,
                                  coef[REG_SHIFT_Y], k1);
            if (op == OP_INT_BOX || op == OP_SUB_BOX) begin
                r.second_x = map_coord(coef[REG_COEF_A], coef[REG_COEF_C], sx, sy,
                                       coef[REG_SHIFT_X], k2);
                r.second_y = map_coord(coef[REG_COEF_B], coef[REG_COEF_D], sx, sy,
                                       coef[REG_SHIFT_Y], k2);
            end else begin
                r.second_x = '0;
                r.second_y = '0;
            end
            r.overflow = sat_seen;
            expected_corners.push_back(r);
        endfunction

        function string show(corner_result_t r);
            return $sformatf("x1=%h y1=%h x2=%h y2=%h ovf=%b",
                             r.first_x, r.first_y, r.second_x, r.second_y, r.overflow);
        endfunction

        function void check_result(corner_result_t got);
            corner_result_t want;
            if (expected_corners.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result beat with nothing pending: %s", $time, show(got));
                mismatches++;
                return;
            end
            want = expected_corners.pop_front();
            if (got.first_x !== want.first_x || got.first_y !== want.first_y ||
                got.second_x !== want.second_x || got.second_y !== want.second_y ||
                got.overflow !== want.overflow) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
                mismatches++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and block ports
    // -----------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [APRT_ADDR_W-1:0] paddr   = '0;
    logic [31:0]            pwdata  = '0;
    logic [31:0]            prdata;
    logic                   pready;

    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_POINT;
    coord_t     s_first_x   = '0;
    coord_t     s_first_y   = '0;
    coord_t     s_second_x  = '0;
    coord_t     s_second_y  = '0;

    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_out_first_x;
    coord_t m_out_first_y;
    coord_t m_out_second_x;
    coord_t m_out_second_y;
    logic   m_overflow;

    // both sides run without gaps while this is set
    bit steady_flow = 1'b0;
    int quiet_cycles = 0;

    transform_scoreboard board;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    affine_point_region_transform_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_second_x     (s_second_x),
        .s_second_y     (s_second_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_first_x  (m_out_first_x),
        .m_out_first_y  (m_out_first_y),
        .m_out_second_x (m_out_second_x),
        .m_out_second_y (m_out_second_y),
        .m_overflow     (m_overflow)
    );

    // -----------------------------------------------------------------------
    // monitors: everything is sampled at the rising edge, inputs move on the
    // falling edge, so no sample depends on event order
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            // check before noting, so a stray result never meets this edge's beat
            if (m_valid && m_ready)
                board.check_result('{m_out_first_x, m_out_first_y,
                                     m_out_second_x, m_out_second_y, m_overflow});
            if (s_valid && s_ready)
                board.note_input(s_operation, s_first_x, s_first_y,
                                 s_second_x, s_second_y);
            if (psel && penable && pwrite && pready)
                board.set_reg(paddr[APRT_ADDR_W-1:2], pwdata);
        end
    end

    // watchdog: any beat or register access counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("affine_point_region_transform_core test failed");
            $finish;
        end
    end

    // result side stalls about one cycle in seven unless steady_flow is set
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------

    // one input beat, with random idle cycles ahead of it unless steady_flow is set
    task automatic send_beat(input logic [1:0] op, input coord_t fx, input coord_t fy,
                             input coord_t sx, input coord_t sy);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_first_x   <= fx;
        s_first_y   <= fy;
        s_second_x  <= sx;
        s_second_y  <= sy;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_corners.size() != 0)
            @(posedge aclk);
    endtask

    // setup cycle, then access cycle; the write lands when pready is high
    task automatic apb_write(input logic [APRT_IDX_W-1:0] idx, input coord_t value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new matrix, written only once the pipeline is empty
    task automatic load_matrix(input coord_t a, input coord_t b, input coord_t c,
                               input coord_t d, input coord_t tx, input coord_t ty);
        drain_results();
        apb_write(REG_COEF_A, a);
        apb_write(REG_COEF_B, b);
        apb_write(REG_COEF_C, c);
        apb_write(REG_COEF_D, d);
        apb_write(REG_SHIFT_X, tx);
        apb_write(REG_SHIFT_Y, ty);
    endtask

    // mostly modest coordinates, some full range, some exact or half values
    function automatic coord_t rand_coord();
        coord_t pick;
        case ($urandom_range(9))
            0, 1, 2, 3: pick = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            4, 5:       pick = $urandom;
            6: begin
                case ($urandom_range(5))
                    0:       pick = C_MAX;
                    1:       pick = C_MIN;
                    2:       pick = '0;
                    3:       pick = Q_ONE;
                    4:       pick = -Q_ONE;
                    default: pick = Q_HALF;
                endcase
            end
            7: begin
                pick         = $urandom;
                pick[FB-1:0] = '0;                          // whole number
            end
            8: begin
                pick         = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                pick[FB-1:0] = {1'b1, {(FB-1){1'b0}}};      // exactly half way
            end
            default: pick = $signed($urandom_range(0, 255)) - 128;
        endcase
        return pick;
    endfunction

    function automatic logic [1:0] rand_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return OP_POINT;
        if (roll < 60)
            return OP_INT_BOX;
        if (roll < 92)
            return OP_SUB_BOX;
        return OP_SPARE;
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_beat(rand_op(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial begin
        board = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // identity matrix from reset: field extremes and every operation
        send_beat(OP_POINT, Q_ONE, 32'sh0002_8000, '0, '0);
        send_beat(OP_POINT, C_MAX, C_MIN, C_MAX, C_MIN);   // second corner must read zero
        send_beat(OP_POINT, C_MIN, C_MAX, '0, '0);
        send_beat(OP_SPARE, 32'sh0001_8000, -32'sh1, C_MAX, C_MAX);  // spare code acts as point
        send_beat(OP_INT_BOX, -32'sh0001_8000, -32'sh0000_4000,
                  32'sh0002_4000, 32'sh0003_0001);
        send_beat(OP_INT_BOX, C_MIN, C_MIN, C_MAX, C_MAX); // ceil of the top overflows
        send_beat(OP_INT_BOX, C_MAX, C_MAX, C_MIN, C_MIN);
        send_beat(OP_SUB_BOX, C_MAX, C_MIN, C_MIN, C_MAX);
        send_beat(OP_SUB_BOX, 32'sh1, -32'sh1, 32'sh7FFF_8000, -32'sh7FFF_8000);
        send_beat(OP_POINT, '0, '0, '0, '0);

        // half gains put exact ties on the rounding point, both signs
        load_matrix(Q_HALF, -Q_HALF, '0, Q_HALF, 32'sh0001_8000, -32'sh0000_8001);
        send_beat(OP_POINT, 32'sh1, 32'sh1, '0, '0);
        send_beat(OP_POINT, -32'sh1, -32'sh1, '0, '0);
        send_beat(OP_POINT, 32'sh3, -32'sh3, '0, '0);
        send_beat(OP_SUB_BOX, 32'sh1, -32'sh1, 32'sh3, 32'sh5);
        send_beat(OP_INT_BOX, 32'sh1, 32'sh1, -32'sh1, -32'sh1);
        send_beat(OP_INT_BOX, '0, '0, '0, '0);             // floor and ceil of translation alone
        send_beat(OP_INT_BOX, C_MIN, C_MAX, C_MAX, C_MIN);
        send_beat(OP_SPARE, 32'sh1, 32'sh1, 32'sh1, 32'sh1);

        // typical scale, shear and fractional translation
        load_matrix(32'sh0001_8000, -32'sh0000_4000, 32'sh0000_C000, -32'sh0002_0000,
                    32'sh000A_8000, -32'sh0003_4000);
        send_random(ITEMS_PER_PHASE);

        // largest and smallest settings everywhere
        load_matrix(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_random(ITEMS_PER_PHASE);
        load_matrix(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_random(ITEMS_PER_PHASE);

        // zero matrix: only the translation and its floor or ceil survive
        load_matrix('0, '0, '0, '0, -Q_HALF, Q_HALF);
        send_random(ITEMS_PER_PHASE);

        // full-range random matrix, no gaps on either side
        steady_flow = 1'b1;
        load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_random(ITEMS_PER_PHASE);
        drain_results();
        steady_flow = 1'b0;

        // random gains within +-4.0 and random translation
        load_matrix($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                    rand_coord(), rand_coord());
        send_random(ITEMS_PER_PHASE);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_corners.size() == 0) begin
            $display("affine_point_region_transform_core test passed");
        end else begin
            $display("affine_point_region_transform_core test failed");
        end
        $finish;
    end

endmodule
